// ===== design/crcsum_pkg.sv =====
// ----------------------------------------------------------------------------
// crcsum_pkg
// Shared types, constants and the byte-wise CRC-32 update for the
// buffer checksum block.
// ----------------------------------------------------------------------------
package crcsum_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 32;
  localparam int unsigned SumW  = 16;
  localparam int unsigned OutDataW = 56;

  localparam logic [CrcW-1:0]  CRC_POLY   = 32'hEDB8_8320;
  localparam logic [CrcW-1:0]  CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0]  CRC_XOROUT = 32'hFFFF_FFFF;
  localparam logic [ByteW-1:0] ERASED     = 8'hFF;

  typedef struct packed {
    logic            all_erased;
    logic [SumW-1:0] byte_sum;
    logic [CrcW-1:0] crc_value;
  } result_t;

  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int i = 0; i < ByteW; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {CrcW{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== design/crcsum_acc.sv =====
// ----------------------------------------------------------------------------
// crcsum_acc
// Running CRC-32, 16-bit byte sum and blank flag; forms the finished
// result for the current byte and restarts after the last byte.
// ----------------------------------------------------------------------------
module crcsum_acc (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [crcsum_pkg::ByteW-1:0] data_byte_i,
  input  logic                         last_byte_i,
  output crcsum_pkg::result_t          result_o
);
  import crcsum_pkg::*;

  logic [CrcW-1:0] crc_q, crc_d, crc_upd;
  logic [SumW-1:0] sum_q, sum_d, sum_upd;
  logic            blank_q, blank_d, blank_upd;

  always_comb begin
    crc_upd   = crc_byte(crc_q, data_byte_i);
    sum_upd   = sum_q + {{(SumW-ByteW){1'b0}}, data_byte_i};
    blank_upd = blank_q & (data_byte_i == ERASED);

    result_o.crc_value  = crc_upd ^ CRC_XOROUT;
    result_o.byte_sum   = sum_upd;
    result_o.all_erased = blank_upd;

    crc_d   = crc_q;
    sum_d   = sum_q;
    blank_d = blank_q;
    if (step_i) begin
      if (last_byte_i) begin
        crc_d   = CRC_INIT;
        sum_d   = '0;
        blank_d = 1'b1;
      end else begin
        crc_d   = crc_upd;
        sum_d   = sum_upd;
        blank_d = blank_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_INIT;
      sum_q   <= '0;
      blank_q <= 1'b1;
    end else begin
      crc_q   <= crc_d;
      sum_q   <= sum_d;
      blank_q <= blank_d;
    end
  end

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_byte_i |=> crc_q == CRC_INIT && sum_q == '0 && blank_q)
    else $error("accumulators not restarted after last byte");

  a_blank_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last_byte_i && data_byte_i != ERASED |=> !blank_q)
    else $error("blank flag kept after non-erased byte");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(crc_q) && $stable(sum_q) && $stable(blank_q))
    else $error("accumulators moved without a step");

endmodule

// ===== design/crcsum_out_reg.sv =====
// ----------------------------------------------------------------------------
// crcsum_out_reg
// Result register holding one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module crcsum_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  crcsum_pkg::result_t result_i,
  input  logic                ready_i,
  output logic                valid_o,
  output crcsum_pkg::result_t result_o
);
  import crcsum_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== design/crc32_sum16_blank_check_top.sv =====
// m_axis_tvalid rises after the last byte passes the input and result registers.
// Throughput: one byte per cycle; the input register frees as the CRC/sum stage
// consumes it, and only a last byte waits while an untaken result is held.
// Reset (rst_ni low, async): CRC restarts at all ones, sum at zero, blank flag
// set, and both pipeline registers empty.
// ----------------------------------------------------------------------------
// crc32_sum16_blank_check_top
// Streaming CRC-32, 16-bit byte sum and blank check over a buffer image.
// ----------------------------------------------------------------------------
module crc32_sum16_blank_check_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [crcsum_pkg::ByteW-1:0]    s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tlast,  // last_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] crc_value, [47:32] byte_sum, [48] all_erased, [55:49] zero
  output logic [crcsum_pkg::OutDataW-1:0] m_axis_tdata
);
  import crcsum_pkg::*;

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             advance;
  logic             load;
  result_t          acc_result;
  result_t          out_result;

  assign advance = in_valid_q & (!in_last_q | !m_axis_tvalid | m_axis_tready);
  assign load    = advance & in_last_q;

  assign s_axis_tready = !in_valid_q | advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  crcsum_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .result_o    (acc_result)
  );

  crcsum_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .result_i (acc_result),
    .ready_i  (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .result_o (out_result)
  );

  assign m_axis_tdata = {{(OutDataW - $bits(result_t)){1'b0}}, out_result};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled while input register empty");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("pending byte lost while stalled");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !m_axis_tvalid || m_axis_tready)
    else $error("result register overwritten before transfer");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams buffer images into crc32_sum16_blank_check_top and checks every
// finished checksum (CRC-32, 16-bit byte sum, blank flag) against a local
// bit-level predictor. Directed buffers cover the field extremes and the
// blank-check cases. Random buffers follow, with random idle cycles on both
// sides and a pause that lets the block drain.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crcsum_pkg::*;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
    int unsigned      gap;
    bit               drain;
  } byte_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata = '0;    // [7:0] data_byte
  logic                s_axis_tlast = 1'b0;  // last_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // [31:0] crc, [47:32] sum, [48] erased

  byte_item_t  pending_q[$];
  result_t     buffer_result_q[$];

  logic [CrcW-1:0] crc_run = CRC_INIT;
  logic [SumW-1:0] sum_run = '0;
  logic            blank_run = 1'b1;

  int unsigned gap_left = 0;
  bit          head_fresh = 1'b1;
  int unsigned stall_left = 0;
  bit          quiet_sink = 1'b0;
  int unsigned results_due = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned blank_results = 0;
  int unsigned errors = 0;
  bit          stim_burst = 1'b0;

  crc32_sum16_blank_check_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] r;
    logic            fb;
    r = crc;
    for (int i = 0; i < ByteW; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic void predict_checksum(input logic [ByteW-1:0] b, input logic last);
    result_t res;
    crc_run = crc_update(crc_run, b);
    sum_run = sum_run + SumW'(b);
    if (b != ERASED) blank_run = 1'b0;
    if (last) begin
      res.crc_value  = crc_run ^ CRC_XOROUT;
      res.byte_sum   = sum_run;
      res.all_erased = blank_run;
      buffer_result_q.push_back(res);
      crc_run   = CRC_INIT;
      sum_run   = '0;
      blank_run = 1'b1;
    end
  endfunction

  function automatic int unsigned draw_gap();
    return stim_burst ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic void add_byte(input logic [ByteW-1:0] b, input logic last,
                                   input bit drain);
    byte_item_t it;
    it.data  = b;
    it.last  = last;
    it.gap   = draw_gap();
    it.drain = drain;
    pending_q.push_back(it);
  endfunction

  function automatic void add_buffer(input logic [ByteW-1:0] bytes[$], input bit drain);
    for (int i = 0; i < bytes.size(); i++)
      add_byte(bytes[i], i == bytes.size() - 1, drain && i == 0);
  endfunction

  function automatic logic [ByteW-1:0] edge_byte();
    logic [ByteW-1:0] picks[6];
    picks = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
    return picks[$urandom_range(0, 5)];
  endfunction

  initial begin
    logic [ByteW-1:0] buf_q[$];
    int unsigned      len;
    int unsigned      kind;
    int unsigned      pos;
    int unsigned      buffers;

    buffers = 0;
    add_buffer('{8'h00}, 1'b0);
    add_buffer('{8'hFF}, 1'b0);
    add_buffer('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
    add_buffer('{8'hFF, 8'hFF, 8'h00}, 1'b0);
    add_buffer('{8'h00, 8'hFF}, 1'b0);
    add_buffer('{8'h80, 8'h01, 8'h7F, 8'hFE}, 1'b0);
    add_buffer('{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39},
               1'b1);
    buffers = 7;

    // long erased buffer so the byte sum wraps past 16 bits
    stim_burst = 1'b1;
    buf_q.delete();
    repeat (270) buf_q.push_back(ERASED);
    add_buffer(buf_q, 1'b1);
    buffers++;

    while (pending_q.size() < 600) begin
      stim_burst = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 7);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      buf_q.delete();
      for (int i = 0; i < len; i++) begin
        case (kind)
          0, 1, 2, 3: buf_q.push_back(ByteW'($urandom));
          4:          buf_q.push_back(ERASED);
          5: begin
            buf_q.push_back(ERASED);
          end
          default:    buf_q.push_back(edge_byte());
        endcase
      end
      if (kind == 5) begin
        pos = $urandom_range(0, len - 1);
        buf_q[pos] = ByteW'($urandom_range(0, 254));
      end
      add_buffer(buf_q, ($urandom_range(0, 49) == 0));
      buffers++;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !s_axis_tvalid && results_seen >= results_due);
    repeat (10) @(posedge clk_i);
    if (buffer_result_q.size() != 0) begin
      $display("%0t leftover: expected %0d more results, got none", $time,
               buffer_result_q.size());
      errors++;
    end
    $display("covered %0d bytes in %0d buffers, %0d results checked (%0d erased)",
             bytes_sent, buffers, results_seen, blank_results);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk_i) begin
    logic fire;
    fire = s_axis_tvalid && s_axis_tready;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        predict_checksum(s_axis_tdata, s_axis_tlast);
        if (s_axis_tlast) results_due++;
        bytes_sent++;
        void'(pending_q.pop_front());
        head_fresh = 1'b1;
      end
      if (!s_axis_tvalid || fire) begin
        if (pending_q.size() != 0 && head_fresh) begin
          gap_left   = pending_q[0].gap;
          head_fresh = 1'b0;
        end
        if (pending_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q[0].drain && results_seen != results_due) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_q[0].data;
          s_axis_tlast  <= pending_q[0].last;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    result_t          exp_res;
    logic [CrcW-1:0]  got_crc;
    logic [SumW-1:0]  got_sum;
    logic             got_erased;
    logic [OutDataW-1:0] got_pad;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        got_crc    = m_axis_tdata[31:0];
        got_sum    = m_axis_tdata[47:32];
        got_erased = m_axis_tdata[48];
        got_pad    = m_axis_tdata >> 49;
        if (buffer_result_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, m_axis_tdata);
          errors++;
        end else begin
          exp_res = buffer_result_q.pop_front();
          if (exp_res.all_erased) blank_results++;
          if (got_crc !== exp_res.crc_value) begin
            $display("%0t crc_value: expected %h, got %h", $time, exp_res.crc_value,
                     got_crc);
            errors++;
          end
          if (got_sum !== exp_res.byte_sum) begin
            $display("%0t byte_sum: expected %h, got %h", $time, exp_res.byte_sum, got_sum);
            errors++;
          end
          if (got_erased !== exp_res.all_erased) begin
            $display("%0t all_erased: expected %b, got %b", $time, exp_res.all_erased,
                     got_erased);
            errors++;
          end
          if (got_pad !== '0) begin
            $display("%0t padding: expected 0, got %h", $time, got_pad);
            errors++;
          end
        end
        if ($urandom_range(0, 19) == 0) quiet_sink = ~quiet_sink;
        stall_left = quiet_sink ? 0 : $urandom_range(0, 10);
      end else if (!m_axis_tready && stall_left > 0) begin
        stall_left--;
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

endmodule
